// ===== hdl/swqt_pkg.sv =====
// Package for the semaphore wait queue table: operation and status codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swqt_pkg;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;
   localparam int PROC_BITS   = 4;

   typedef enum logic [1:0] {
      OP_BLOCK  = 2'd0,
      OP_WAKE   = 2'd1,
      OP_CANCEL = 2'd2,
      OP_PEEK   = 2'd3
   } op_type;

   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ1,
      S_READ2,
      S_WRITE,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

// ===== hdl/swqt_if.sv =====
// Valid/ready channel carrying one payload beat.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface swqt_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/semaphore_wait_queue_table.sv =====
// Semaphore wait queue table.
// req channel: beat = {op, sem_addr, proc_id}; rsp channel: beat = {status,
// result_proc}, one response per request.
// A request is taken only when the block is idle. It then walks through:
// key match (valid bits and keys held in flops, one compare per descriptor),
// a first read of the descriptor and process link memories, a second read of
// the neighbour links, a write-back state, and a response state. rsp_valid
// rises in the response state, which follows READ1, READ2 and WRITE; the
// response beat is taken when rsp_ready is high there. The next request is
// taken the cycle after the response beat, so one request is in flight at a
// time. The link memories (head, tail, next, prev, slot) are synchronous RAMs
// with registered reads.
// Reset clears the descriptor-in-use and process-blocked flags at once; the
// other stores are never read before being written, so no clearing pass is
// needed and a request can be accepted in the first cycle after reset.
// While rsp_ready is low the response is held and no new request is taken.
// Depends on swqt_pkg and swqt_if.
`timescale 1ns / 1ps
`default_nettype none
module semaphore_wait_queue_table #(
   parameter int MAX_PROCS     = 16,
   parameter int SEM_ADDR_BITS = 31
) (
   input  wire logic clock,
   input  wire logic reset,
   swqt_if.sink      req,
   swqt_if.source    rsp
);
   import swqt_pkg::*;

   localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

   // request fields
   logic [OP_BITS-1:0]       req_op;
   logic [SEM_ADDR_BITS-1:0] req_sem_addr;
   logic [PROC_BITS-1:0]     req_proc_id;
   assign req_op       = req.data.op;
   assign req_sem_addr = req.data.sem_addr[SEM_ADDR_BITS-1:0];
   assign req_proc_id  = req.data.proc_id;

   state_type state_ff, state_in;

   logic [OP_BITS-1:0]       op_ff;
   logic [SEM_ADDR_BITS-1:0] key_ff;
   logic [PROC_BITS-1:0]     pid_ff;
   logic                     pid_ok_ff;

   logic [SEM_ADDR_BITS-1:0] desc_key_ff [MAX_PROCS];
   logic [MAX_PROCS-1:0]     desc_in_use_ff;
   logic [MAX_PROCS-1:0]     proc_blocked_ff;

   logic [IW-1:0] queue_head_mem [MAX_PROCS];
   logic [IW-1:0] queue_tail_mem [MAX_PROCS];
   logic [IW-1:0] proc_next_mem  [MAX_PROCS];
   logic [IW-1:0] proc_prev_mem  [MAX_PROCS];
   logic [IW-1:0] proc_slot_mem  [MAX_PROCS];

   // match results captured at acceptance
   logic          hit_ff, free_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;
   logic          hit_c, free_c;
   logic [IW-1:0] hit_idx_c, free_idx_c;

   always_comb begin
      hit_c = 1'b0;
      hit_idx_c = '0;
      free_c = 1'b0;
      free_idx_c = '0;
      for (int d = MAX_PROCS - 1; d >= 0; d--) begin
         if (desc_in_use_ff[d] && desc_key_ff[d] == req_sem_addr) begin
            hit_c = 1'b1;
            hit_idx_c = IW'(d);
         end
         if (!desc_in_use_ff[d]) begin
            free_c = 1'b1;
            free_idx_c = IW'(d);
         end
      end
   end

   // first read stage: descriptor head/tail at hit, slot and prev of pid
   logic [IW-1:0] rd_head_ff, rd_tail_ff, rd_slot_ff, rd_next_ff, rd_prev_ff;
   // second read stage
   logic [IW-1:0] r2_head_ff, r2_tail_ff;
   logic [IW-1:0] tgt_ff, tgt_in, dsc_ff, dsc_in;

   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [PROC_BITS-1:0]   result_ff, result_in;
   logic                   do_write_in;

   logic accept;
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.data.status      = status_ff;
   assign rsp.data.result_proc = result_ff;

   logic [IW-1:0] pidx;
   assign pidx = IW'(pid_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_READ1;
         S_READ1: state_in = S_READ2;
         S_READ2: state_in = S_WRITE;
         S_WRITE: state_in = S_RESP;
         S_RESP:  if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         key_ff      <= req_sem_addr;
         pid_ff      <= req_proc_id;
         pid_ok_ff   <= (32'(req_proc_id) < MAX_PROCS);
         hit_ff      <= hit_c;
         hit_idx_ff  <= hit_idx_c;
         free_ok_ff  <= free_c;
         free_idx_ff <= free_idx_c;
      end
   end

   // READ1: read descriptor and process entries
   always_ff @(posedge clock) begin
      if (state_ff == S_READ1) begin
         rd_head_ff <= queue_head_mem[hit_idx_ff];
         rd_tail_ff <= queue_tail_mem[hit_idx_ff];
         rd_slot_ff <= proc_slot_mem[pidx];
         rd_prev_ff <= proc_prev_mem[pidx];
      end
   end

   // Target process and descriptor: wake uses the head, cancel the pid.
   always_comb begin
      tgt_in = pidx;
      dsc_in = rd_slot_ff;
      if (op_ff == OP_WAKE) begin
         tgt_in = rd_head_ff;
         dsc_in = hit_idx_ff;
      end
   end

   // READ2: next link of the target and its descriptor's head/tail
   always_ff @(posedge clock) begin
      if (state_ff == S_READ2) begin
         tgt_ff     <= tgt_in;
         dsc_ff     <= dsc_in;
         r2_head_ff <= queue_head_mem[dsc_in];
         r2_tail_ff <= queue_tail_mem[dsc_in];
         rd_next_ff <= proc_next_mem[tgt_in];
      end
   end

   function automatic op_type op_or(input logic [OP_BITS-1:0] v);
      return op_type'(v);
   endfunction

   // decision, evaluated in WRITE
   always_comb begin
      status_in = ST_MISS;
      result_in = '0;
      do_write_in = 1'b0;
      case (op_or(op_ff))
         OP_BLOCK: begin
            if (pid_ok_ff && !proc_blocked_ff[pidx]) begin
               if (hit_ff || free_ok_ff) begin
                  status_in = ST_OK;
                  do_write_in = 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end
         end
         OP_WAKE: begin
            if (hit_ff) begin
               status_in = ST_OK;
               result_in = PROC_BITS'(rd_head_ff);
               do_write_in = 1'b1;
            end
         end
         OP_CANCEL: begin
            if (pid_ok_ff && proc_blocked_ff[pidx]) begin
               status_in = ST_OK;
               result_in = pid_ff;
               do_write_in = 1'b1;
            end
         end
         default: begin
            if (hit_ff) begin
               status_in = ST_OK;
               result_in = PROC_BITS'(rd_head_ff);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         status_ff   <= status_in;
         result_ff   <= result_in;
      end
   end

   // write-back: flags
   logic is_head, is_tail;
   assign is_head = (r2_head_ff == tgt_ff);
   assign is_tail = (r2_tail_ff == tgt_ff);

   logic wr_go;
   assign wr_go = (state_ff == S_WRITE) && do_write_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_in_use_ff  <= '0;
         proc_blocked_ff <= '0;
      end else if (wr_go) begin
         if (op_ff == OP_BLOCK) begin
            proc_blocked_ff[pidx] <= 1'b1;
            if (!hit_ff) begin
               desc_in_use_ff[free_idx_ff] <= 1'b1;
            end
         end else begin
            proc_blocked_ff[tgt_ff] <= 1'b0;
            if (is_head && is_tail) begin
               desc_in_use_ff[dsc_ff] <= 1'b0;
            end
         end
      end
   end

   // write-back: memories
   always_ff @(posedge clock) begin
      if (wr_go) begin
         if (op_ff == OP_BLOCK) begin
            if (hit_ff) begin
               proc_next_mem[rd_tail_ff]  <= pidx;
               proc_prev_mem[pidx]        <= rd_tail_ff;
               queue_tail_mem[hit_idx_ff] <= pidx;
               proc_slot_mem[pidx]        <= hit_idx_ff;
            end else begin
               desc_key_ff[free_idx_ff]    <= key_ff;
               queue_head_mem[free_idx_ff] <= pidx;
               queue_tail_mem[free_idx_ff] <= pidx;
               proc_slot_mem[pidx]         <= free_idx_ff;
            end
         end else if (!(is_head && is_tail)) begin
            if (is_head) begin
               queue_head_mem[dsc_ff] <= rd_next_ff;
            end else if (is_tail) begin
               queue_tail_mem[dsc_ff] <= rd_prev_ff;
            end else begin
               proc_next_mem[rd_prev_ff] <= rd_next_ff;
               proc_prev_mem[rd_next_ff] <= rd_prev_ff;
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== verif/semaphore_wait_queue_table_test.sv =====
// Self-checking bench for semaphore_wait_queue_table: directed and random
// block/wake/cancel/peek traffic, checked beat by beat against a local predictor.
// Depends on swqt_pkg, swqt_if and the block itself.
`timescale 1ns / 1ps
module semaphore_wait_queue_table_test;
   import swqt_pkg::*;

   localparam int NPROC      = 16;
   localparam int ADDR_BITS  = 31;
   localparam int CYCLE_CAP  = 400000;

   typedef struct packed {
      op_type                 op;
      logic [ADDR_BITS-1:0]   sem_addr;
      logic [PROC_BITS-1:0]   proc_id;
   } req_beat;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [PROC_BITS-1:0]   result_proc;
   } rsp_beat;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swqt_if #(.payload_type(req_beat)) req_ch ();
   swqt_if #(.payload_type(rsp_beat)) rsp_ch ();

   semaphore_wait_queue_table #(.MAX_PROCS(NPROC), .SEM_ADDR_BITS(ADDR_BITS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [ADDR_BITS-1:0] sem_key   [NPROC];
   logic                 sem_live  [NPROC] = '{default: 1'b0};
   logic [3:0]           wq_head   [NPROC];
   logic [3:0]           wq_tail   [NPROC];
   logic [3:0]           link_next [NPROC];
   logic [3:0]           link_prev [NPROC];
   logic [3:0]           waits_on  [NPROC];
   logic                 asleep    [NPROC] = '{default: 1'b0};

   req_beat pending_reqs [$];
   rsp_beat due_rsps [$];
   int      errors = 0;
   int      cycles = 0;
   int      op_seen [4];
   int      st_seen [3];
   int      checked = 0;
   logic    quiet = 1'b0;
   logic    [ADDR_BITS-1:0] addr_pool [24];

   function automatic int lookup_sem(logic [ADDR_BITS-1:0] key);
      for (int d = 0; d < NPROC; d++)
         if (sem_live[d] && sem_key[d] == key) return d;
      return NPROC;
   endfunction

   function automatic void dequeue_proc(int p);
      int d;
      d = int'(waits_on[p]);
      if (wq_head[d] == p && wq_tail[d] == p) sem_live[d] = 1'b0;
      else if (wq_head[d] == p) wq_head[d] = link_next[p];
      else if (wq_tail[d] == p) wq_tail[d] = link_prev[p];
      else begin
         link_next[link_prev[p]] = link_next[p];
         link_prev[link_next[p]] = link_prev[p];
      end
      asleep[p] = 1'b0;
   endfunction

   function automatic rsp_beat apply_request(req_beat r);
      rsp_beat o;
      int d, p;
      o = '{status: ST_MISS, result_proc: '0};
      p = int'(r.proc_id);
      case (r.op)
         OP_BLOCK: begin
            if (!asleep[p]) begin
               d = lookup_sem(r.sem_addr);
               if (d < NPROC) begin
                  link_next[wq_tail[d]] = p[3:0];
                  link_prev[p] = wq_tail[d];
                  wq_tail[d] = p[3:0];
                  o.status = ST_OK;
               end else begin
                  for (d = 0; d < NPROC; d++) if (!sem_live[d]) break;
                  if (d < NPROC) begin
                     sem_live[d] = 1'b1;
                     sem_key[d]  = r.sem_addr;
                     wq_head[d]  = p[3:0];
                     wq_tail[d]  = p[3:0];
                     o.status    = ST_OK;
                  end else o.status = ST_FULL;
               end
               if (o.status == ST_OK) begin
                  waits_on[p] = d[3:0];
                  asleep[p]   = 1'b1;
               end
            end
         end
         OP_WAKE: begin
            d = lookup_sem(r.sem_addr);
            if (d < NPROC) begin
               o = '{status: ST_OK, result_proc: wq_head[d]};
               dequeue_proc(int'(wq_head[d]));
            end
         end
         OP_CANCEL: begin
            if (asleep[p]) begin
               o = '{status: ST_OK, result_proc: p[3:0]};
               dequeue_proc(p);
            end
         end
         default: begin
            d = lookup_sem(r.sem_addr);
            if (d < NPROC) o = '{status: ST_OK, result_proc: wq_head[d]};
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      errors++;
   endtask

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 16) - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_beat r;
            r = pending_reqs.pop_front();
            due_rsps.push_back(apply_request(r));
            op_seen[r.op]++;
            req_ch.data  <= r;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   int stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_rsps.size() == 0) begin
               report_mismatch("unexpected beat", 32'(rsp_ch.data), 0);
            end else begin
               rsp_beat w;
               w = due_rsps.pop_front();
               if (rsp_ch.data.status != w.status)
                  report_mismatch("status", 32'(rsp_ch.data.status), 32'(w.status));
               if (rsp_ch.data.result_proc != w.result_proc)
                  report_mismatch("result_proc", 32'(rsp_ch.data.result_proc),
                                  32'(w.result_proc));
               if (w.status <= ST_MISS) st_seen[w.status]++;
               checked++;
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall <= $urandom_range(1, 16) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_beat make_req(op_type op, logic [ADDR_BITS-1:0] a, int p);
      req_beat r;
      r.op = op;
      r.sem_addr = a;
      r.proc_id = p[3:0];
      return r;
   endfunction

   function automatic logic [ADDR_BITS-1:0] pick_addr();
      if ($urandom_range(0, 15) == 0) return ADDR_BITS'($urandom());
      return addr_pool[$urandom_range(0, 23)];
   endfunction

   task automatic queue_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 40)
            pending_reqs.push_back(make_req(OP_BLOCK, pick_addr(), $urandom_range(0, 15)));
         else if (k < 65)
            pending_reqs.push_back(make_req(OP_WAKE, pick_addr(), $urandom_range(0, 15)));
         else if (k < 85)
            pending_reqs.push_back(make_req(OP_CANCEL, ADDR_BITS'($urandom()),
                                            $urandom_range(0, 15)));
         else
            pending_reqs.push_back(make_req(OP_PEEK, pick_addr(), $urandom_range(0, 15)));
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clock);
      while (due_rsps.size() > 0) @(posedge clock);
   endtask

   initial begin
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      addr_pool[2] = 31'd1;
      addr_pool[3] = 31'h7fff_fffe;
      for (int i = 4; i < 24; i++) addr_pool[i] = ADDR_BITS'($urandom());
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty misses, block every process, queue order, cancels
      pending_reqs.push_back(make_req(OP_WAKE, '0, 0));
      pending_reqs.push_back(make_req(OP_PEEK, '1, 0));
      pending_reqs.push_back(make_req(OP_CANCEL, '0, 15));
      for (int p = 0; p < NPROC; p++)
         pending_reqs.push_back(make_req(OP_BLOCK, {ADDR_BITS{p[0]}}, p));
      pending_reqs.push_back(make_req(OP_BLOCK, 31'h5555_5555, 3));   // already asleep
      pending_reqs.push_back(make_req(OP_PEEK, '1, 0));
      pending_reqs.push_back(make_req(OP_CANCEL, '0, 4));             // middle of queue
      pending_reqs.push_back(make_req(OP_CANCEL, '0, 14));            // tail
      pending_reqs.push_back(make_req(OP_WAKE, '1, 0));               // head
      wait_drained();

      // sender holds off until everything has come back
      queue_random(500);
      wait_drained();
      queue_random(450);
      wait_drained();
      quiet <= 1'b1;
      queue_random(100);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("%0d beats checked: block %0d, wake %0d, cancel %0d, peek %0d",
               checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("statuses seen: ok %0d, full %0d, miss %0d", st_seen[0], st_seen[1], st_seen[2]);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
